// File: rtl/rlfs_pkg.sv
// package for the follow smoother: types, register codes, constants
// no dependencies

package rlfs_pkg;

  localparam int BypassZOnJump = 1;

  // iteration counts tied to the datapath widths
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 56;

  localparam logic [2:0] REG_OFFSET_BACK = 3'd0;
  localparam logic [2:0] REG_OFFSET_UP   = 3'd1;
  localparam logic [2:0] REG_H_STIFF     = 3'd2;
  localparam logic [2:0] REG_H_CAP       = 3'd3;
  localparam logic [2:0] REG_H_RESP      = 3'd4;
  localparam logic [2:0] REG_V_STIFF     = 3'd5;
  localparam logic [2:0] REG_V_CAP       = 3'd6;
  localparam logic [2:0] REG_V_RESP      = 3'd7;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // controller commands to the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch input word, compute goal
    OP_PLACE,    // follower position takes the goal
    OP_ERR,      // errors
    OP_HGV,      // horizontal goal velocities
    OP_SQ,       // squares of |gv|
    OP_MAG,      // sum of squares and cap compare
    OP_SQRT_INIT,
    OP_SQRT,     // one sqrt step
    OP_DIV_INIT, // start dividing gv*cap by m
    OP_DIV,      // one division step (x and y together)
    OP_VGV,      // vertical goal velocity and blend factors
    OP_BLEND,    // velocity blend
    OP_ADV       // position advance
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GOAL, ST_ERR, ST_HGV, ST_SQ, ST_MAG, ST_CAP, ST_SQRT, ST_DIVI, ST_DIV,
    ST_VGV, ST_BLEND, ST_ADV, ST_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic place;
    logic cap_hit;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(S32_MAX)) return S32_MAX;
    if (v < 66'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

endpackage

// File: rtl/rate_limited_follow_smoother.sv
// follow smoother top level: one word in, one position word out
// result registered after the goal step in place mode, else after the error,
// velocity, square, magnitude, cap, blend and advance steps, with the 32-step square
// root and 56-step restoring divider in between for a capped horizontal speed
// one word in flight; next word accepted the cycle after the result is taken
// synchronous active-low reset: configuration registers to defaults, follower state zero
// depends on rlfs_pkg, rlfs_ctrl, rlfs_dp

module rate_limited_follow_smoother import rlfs_pkg::*; #(
  parameter int BYPASS_Z_ON_JUMP = BypassZOnJump
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic [15:0]        in_step_time,
  input  logic               in_jumping,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  rlfs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  // arithmetic and state
  rlfs_dp #(.BypassZ(BYPASS_Z_ON_JUMP)) u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_we, .cfg_idx, .cfg_data,
    .in_mode, .in_target_x, .in_target_y, .in_target_z, .in_step_time,
    .in_jumping, .out_pos_x, .out_pos_y, .out_pos_z
  );

endmodule

// File: rtl/rlfs_ctrl.sv
// controller state machine for the follow smoother
// depends on rlfs_pkg

module rlfs_ctrl import rlfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam int CW = $clog2(DivSteps + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_GOAL;
      ST_GOAL:  state_nxt = stat.place ? ST_OUT : ST_ERR;
      ST_ERR:   state_nxt = ST_HGV;
      ST_HGV:   state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_MAG;
      ST_MAG:   state_nxt = ST_CAP;
      ST_CAP: begin
        cnt_nxt = '0;
        state_nxt = stat.cap_hit ? ST_SQRT : ST_VGV;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(SqrtSteps - 1)) state_nxt = ST_DIVI;
      end
      ST_DIVI: begin
        cnt_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DivSteps - 1)) state_nxt = ST_VGV;
      end
      ST_VGV:   state_nxt = ST_BLEND;
      ST_BLEND: state_nxt = ST_ADV;
      ST_ADV:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.op    = OP_NONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_GOAL:  cmd.op = stat.place ? OP_PLACE : OP_NONE;
      ST_ERR:   cmd.op = OP_ERR;
      ST_HGV:   cmd.op = OP_HGV;
      ST_SQ:    cmd.op = OP_SQ;
      ST_MAG:   cmd.op = OP_MAG;
      ST_CAP:   cmd.op = stat.cap_hit ? OP_SQRT_INIT : OP_NONE;
      ST_SQRT:  cmd.op = OP_SQRT;
      ST_DIVI:  cmd.op = OP_DIV_INIT;
      ST_DIV:   cmd.op = OP_DIV;
      ST_VGV:   cmd.op = OP_VGV;
      ST_BLEND: cmd.op = OP_BLEND;
      ST_ADV:   cmd.op = OP_ADV;
      ST_OUT:   out_valid = 1'b1;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/rlfs_dp.sv
// datapath for the follow smoother: registers, state, sqrt and divide units
// depends on rlfs_pkg

module rlfs_dp import rlfs_pkg::*; #(
  parameter int BypassZ = BypassZOnJump
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [23:0]         cfg_data,
  input  logic                in_mode,
  input  logic signed [31:0]  in_target_x,
  input  logic signed [31:0]  in_target_y,
  input  logic signed [31:0]  in_target_z,
  input  logic [15:0]         in_step_time,
  input  logic                in_jumping,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_pos_z
);

  // configuration registers
  logic [23:0] off_back_r, h_cap_r, v_cap_r;
  logic signed [23:0] off_up_r;
  logic [15:0] h_stiff_r, h_resp_r, v_stiff_r, v_resp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_back_r <= 24'd177408;
      off_up_r   <= 24'sd102400;
      h_stiff_r  <= 16'd1280;
      h_cap_r    <= 24'd512000;
      h_resp_r   <= 16'd2560;
      v_stiff_r  <= 16'd1280;
      v_cap_r    <= 24'd512000;
      v_resp_r   <= 16'd2560;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OFFSET_BACK: off_back_r <= cfg_data;
        REG_OFFSET_UP:   off_up_r   <= cfg_data;
        REG_H_STIFF:     h_stiff_r  <= cfg_data[15:0];
        REG_H_CAP:       h_cap_r    <= cfg_data;
        REG_H_RESP:      h_resp_r   <= cfg_data[15:0];
        REG_V_STIFF:     v_stiff_r  <= cfg_data[15:0];
        REG_V_CAP:       v_cap_r    <= cfg_data;
        REG_V_RESP:      v_resp_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // follower state
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  // work registers
  logic signed [31:0] goal_r [3];
  logic signed [31:0] err_r [3];
  logic signed [31:0] gv_r [3];
  logic [15:0] dt_r;
  logic jump_r, place_r;
  logic [63:0] sqx_r, sqy_r;
  logic cap_hit_r;
  logic [16:0] fh_r, fv_r;
  // sqrt unit
  logic [64:0] sq_n_r, sq_res_r, sq_bit_r;
  // divider unit: separate x and y quotients and remainders, common divisor
  logic [55:0] qx_r, qy_r;
  logic [31:0] remx_r, remy_r;
  logic [31:0] m_r;
  logic negx_r, negy_r;

  assign stat.place   = place_r;
  assign stat.cap_hit = cap_hit_r;
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];

  // combinational helpers
  logic signed [65:0] hprod [2];
  logic signed [65:0] vprod;
  logic signed [31:0] vgv;
  logic [31:0] ax, ay;
  logic [64:0] sq_try;
  logic [32:0] dx_try, dy_try;
  logic [31:0] fh_raw, fv_raw;
  logic signed [65:0] bprod [3];
  logic [16:0] fsel [3];
  logic signed [31:0] gvs [3];

  always_comb begin
    hprod[0] = (66'(err_r[0]) * $signed({50'd0, h_stiff_r})) >>> 8;
    hprod[1] = (66'(err_r[1]) * $signed({50'd0, h_stiff_r})) >>> 8;
    vprod    = (66'(err_r[2]) * $signed({50'd0, v_stiff_r})) >>> 8;
    // vertical goal velocity with clamp
    vgv = (jump_r && BypassZ != 0) ? err_r[2] : sat32(vprod);
    if (vgv > $signed({8'd0, v_cap_r})) vgv = $signed({8'd0, v_cap_r});
    if (vgv < -$signed({8'd0, v_cap_r})) vgv = -$signed({8'd0, v_cap_r});
    ax = gv_r[0][31] ? 32'(-gv_r[0]) : gv_r[0];
    ay = gv_r[1][31] ? 32'(-gv_r[1]) : gv_r[1];
    sq_try = sq_res_r + sq_bit_r;
    dx_try = {remx_r, qx_r[55]} - {1'b0, m_r};
    dy_try = {remy_r, qy_r[55]} - {1'b0, m_r};
    fh_raw = (32'(h_resp_r) * 32'(dt_r)) >> 8;
    fv_raw = (32'(v_resp_r) * 32'(dt_r)) >> 8;
    fsel[0] = fh_r; fsel[1] = fh_r; fsel[2] = fv_r;
    gvs[0] = gv_r[0]; gvs[1] = gv_r[1]; gvs[2] = gv_r[2];
    for (int i = 0; i < 3; i++) begin
      bprod[i] = ((66'(gvs[i]) - 66'(vel_r[i])) * $signed({49'd0, fsel[i]})) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      place_r   <= 1'b0;
      cap_hit_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          goal_r[0] <= sat32(66'(in_target_x) - 66'(off_back_r));
          goal_r[1] <= in_target_y;
          goal_r[2] <= sat32(66'(in_target_z) + 66'(off_up_r));
          dt_r    <= in_step_time;
          jump_r  <= in_jumping;
          place_r <= in_mode;
        end
        OP_PLACE: for (int i = 0; i < 3; i++) pos_r[i] <= goal_r[i];
        OP_ERR: for (int i = 0; i < 3; i++)
          err_r[i] <= sat32(66'(goal_r[i]) - 66'(pos_r[i]));
        OP_HGV: begin
          gv_r[0] <= sat32(hprod[0]);
          gv_r[1] <= sat32(hprod[1]);
        end
        OP_SQ: begin
          sqx_r <= 64'(ax) * 64'(ax);
          sqy_r <= 64'(ay) * 64'(ay);
        end
        OP_MAG: begin
          sq_n_r    <= 65'(sqx_r) + 65'(sqy_r);
          cap_hit_r <= (65'(sqx_r) + 65'(sqy_r)) > 65'(64'(h_cap_r) * 64'(h_cap_r));
        end
        OP_SQRT_INIT: begin
          // sum of squares is at most 2^63, so the top trial bit is 2^62
          sq_res_r <= '0;
          sq_bit_r <= 65'd1 << 62;
        end
        OP_SQRT: begin
          if (sq_n_r >= sq_try) begin
            sq_n_r   <= sq_n_r - sq_try;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
        end
        OP_DIV_INIT: begin
          // m is at least 1 here; dividends are |gv|*cap
          m_r    <= (sq_res_r[31:0] == 32'd0) ? 32'd1 : sq_res_r[31:0];
          negx_r <= gv_r[0][31];
          negy_r <= gv_r[1][31];
          qx_r   <= 56'(ax) * 56'(h_cap_r);
          qy_r   <= 56'(ay) * 56'(h_cap_r);
          remx_r <= '0;
          remy_r <= '0;
        end
        OP_DIV: begin
          if (!dx_try[32]) begin
            remx_r <= dx_try[31:0];
            qx_r   <= {qx_r[54:0], 1'b1};
          end else begin
            remx_r <= {remx_r[30:0], qx_r[55]};
            qx_r   <= {qx_r[54:0], 1'b0};
          end
          if (!dy_try[32]) begin
            remy_r <= dy_try[31:0];
            qy_r   <= {qy_r[54:0], 1'b1};
          end else begin
            remy_r <= {remy_r[30:0], qy_r[55]};
            qy_r   <= {qy_r[54:0], 1'b0};
          end
        end
        OP_VGV: begin
          // scaled components fit in 32 bits since the quotient is at most |gv|
          if (cap_hit_r) begin
            gv_r[0] <= negx_r ? 32'(-qx_r[31:0]) : qx_r[31:0];
            gv_r[1] <= negy_r ? 32'(-qy_r[31:0]) : qy_r[31:0];
          end
          gv_r[2] <= vgv;
          fh_r <= (fh_raw > 32'd65536) ? 17'd65536 : fh_raw[16:0];
          fv_r <= (fv_raw > 32'd65536) ? 17'd65536 : fv_raw[16:0];
        end
        OP_BLEND: for (int i = 0; i < 3; i++)
          vel_r[i] <= sat32(66'(vel_r[i]) + bprod[i]);
        OP_ADV: for (int i = 0; i < 3; i++)
          pos_r[i] <= sat32(66'(pos_r[i]) +
                      ((66'(vel_r[i]) * $signed({50'd0, dt_r})) >>> 16));
        default: ;
      endcase
    end
  end

endmodule
